@@ src/tlca_pkg.sv @@
// tlca_pkg: shared constants, field types, datapath op codes and the
// command/status structs between controller and datapath
// no dependencies
`timescale 1ns / 1ps

package tlca_pkg;

   // sizing
   localparam int NODES         = 1024;
   localparam int LEVELS        = 10;
   localparam int WEIGHT_BITS   = 30;
   localparam int NODE_BITS     = $clog2(NODES);
   localparam int LVL_BITS      = $clog2(LEVELS);
   localparam int DEPTH_BITS    = 11;
   localparam int DIST_BITS     = 40;
   localparam int PATH_BITS     = DIST_BITS + 1;
   localparam int ANC_ADDR_BITS = NODE_BITS + LVL_BITS;
   localparam int ANC_ENTRIES   = 1 << ANC_ADDR_BITS;

   localparam logic [LVL_BITS-1:0] LVL_LAST = LVL_BITS'(LEVELS - 1);

   // command field codes
   localparam logic CMD_LOAD  = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   typedef logic [NODE_BITS-1:0]   node_type;
   typedef logic [LVL_BITS-1:0]    lvl_type;
   typedef logic [DEPTH_BITS-1:0]  depth_type;
   typedef logic [DIST_BITS-1:0]   dist_type;
   typedef logic [PATH_BITS-1:0]   path_type;
   typedef logic [WEIGHT_BITS-1:0] weight_type;

   // one datapath operation per cycle
   typedef enum logic [3:0] {
      OP_IDLE       = 4'd0,
      OP_CAPTURE    = 4'd1,
      OP_LD_RD      = 4'd2,
      OP_LD_WR      = 4'd3,
      OP_LD_ANC_RD  = 4'd4,
      OP_LD_ANC_WR  = 4'd5,
      OP_Q_RD       = 4'd6,
      OP_Q_SWAP     = 4'd7,
      OP_LIFT_ANC   = 4'd8,
      OP_LIFT_DEP   = 4'd9,
      OP_LIFT_CMP   = 4'd10,
      OP_Q_EQ       = 4'd11,
      OP_CLIMB      = 4'd12,
      OP_Q_PAR      = 4'd13,
      OP_Q_DIST     = 4'd14,
      OP_Q_OUT      = 4'd15
   } op_type;

   typedef struct packed {
      op_type  op;
      lvl_type lvl;
   } cmd_type;

   typedef struct packed {
      logic is_query;
      logic node_zero;
      logic nodes_equal;
      logic rsp_busy;
   } status_type;

endpackage

@@ src/tree_lca_distance_query_unit.sv @@
// tree_lca_distance_query_unit: binary lifting lca and path length engine,
// controller plus datapath; depends on tlca_pkg, tlca_ctrl, tlca_datapath
// load item: parent lookup and write, then the ancestor ladder level by level
// query item: depth fetch, lift and climb; the climb is skipped when the lifted
// node already meets the other; one ancestor level per step, held while rsp stalls
// one item at a time; sync reset idles the sequencer and drops rsp_valid, tables kept
`timescale 1ns / 1ps

module tree_lca_distance_query_unit (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   req_command,
   input  tlca_pkg::node_type     req_node,
   input  tlca_pkg::node_type     req_other_node,
   input  tlca_pkg::weight_type   req_weight,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output tlca_pkg::node_type     rsp_common_ancestor,
   output tlca_pkg::path_type     rsp_path_length
);

   tlca_pkg::cmd_type    cmd;
   tlca_pkg::status_type status;

   // sequencer
   tlca_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // tables and arithmetic
   tlca_datapath u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .req_command         (req_command),
      .req_node            (req_node),
      .req_other_node      (req_other_node),
      .req_weight          (req_weight),
      .rsp_ready           (rsp_ready),
      .rsp_valid           (rsp_valid),
      .rsp_common_ancestor (rsp_common_ancestor),
      .rsp_path_length     (rsp_path_length)
   );

endmodule

@@ src/tlca_ctrl.sv @@
// tlca_ctrl: sequencer for node loads and lca queries, drives one datapath
// op and a table level each cycle; depends on tlca_pkg
`timescale 1ns / 1ps

module tlca_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  tlca_pkg::status_type   status,
   output tlca_pkg::cmd_type      cmd
);

   typedef enum logic [15:0] {
      ST_IDLE      = 16'b0000_0000_0000_0001,
      ST_DECODE    = 16'b0000_0000_0000_0010,
      ST_LD_RD     = 16'b0000_0000_0000_0100,
      ST_LD_WR     = 16'b0000_0000_0000_1000,
      ST_LD_ANC_RD = 16'b0000_0000_0001_0000,
      ST_LD_ANC_WR = 16'b0000_0000_0010_0000,
      ST_Q_RD      = 16'b0000_0000_0100_0000,
      ST_Q_SWAP    = 16'b0000_0000_1000_0000,
      ST_LIFT_ANC  = 16'b0000_0001_0000_0000,
      ST_LIFT_DEP  = 16'b0000_0010_0000_0000,
      ST_LIFT_CMP  = 16'b0000_0100_0000_0000,
      ST_Q_EQ      = 16'b0000_1000_0000_0000,
      ST_CLIMB     = 16'b0001_0000_0000_0000,
      ST_Q_PAR     = 16'b0010_0000_0000_0000,
      ST_Q_DIST    = 16'b0100_0000_0000_0000,
      ST_Q_OUT     = 16'b1000_0000_0000_0000
   } state_type;

   state_type         state_ff, state_in;
   tlca_pkg::lvl_type lv_ff, lv_in;
   tlca_pkg::lvl_type lv_dec;

   assign lv_dec    = lv_ff - tlca_pkg::LVL_BITS'(1);
   assign req_ready = (state_ff == ST_IDLE);

   // next state, level counter and datapath command
   always_comb begin
      state_in = state_ff;
      lv_in    = lv_ff;
      cmd.op   = tlca_pkg::OP_IDLE;
      cmd.lvl  = lv_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.op   = tlca_pkg::OP_CAPTURE;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            if (status.is_query) begin
               state_in = ST_Q_RD;
            end else if (status.node_zero) begin
               state_in = ST_IDLE;
            end else begin
               state_in = ST_LD_RD;
            end
         end
         // load: parent lookup, then one ancestor level per read and write pair
         ST_LD_RD: begin
            cmd.op   = tlca_pkg::OP_LD_RD;
            cmd.lvl  = '0;
            state_in = ST_LD_WR;
         end
         ST_LD_WR: begin
            cmd.op   = tlca_pkg::OP_LD_WR;
            lv_in    = tlca_pkg::LVL_BITS'(1);
            state_in = ST_LD_ANC_RD;
         end
         ST_LD_ANC_RD: begin
            cmd.op   = tlca_pkg::OP_LD_ANC_RD;
            cmd.lvl  = lv_dec;
            state_in = ST_LD_ANC_WR;
         end
         ST_LD_ANC_WR: begin
            cmd.op  = tlca_pkg::OP_LD_ANC_WR;
            cmd.lvl = lv_ff;
            if (lv_ff == tlca_pkg::LVL_LAST) begin
               state_in = ST_IDLE;
            end else begin
               lv_in    = lv_ff + tlca_pkg::LVL_BITS'(1);
               state_in = ST_LD_ANC_RD;
            end
         end
         // query: fetch depths and distances of both nodes
         ST_Q_RD: begin
            cmd.op   = tlca_pkg::OP_Q_RD;
            state_in = ST_Q_SWAP;
         end
         ST_Q_SWAP: begin
            cmd.op   = tlca_pkg::OP_Q_SWAP;
            lv_in    = tlca_pkg::LVL_LAST;
            state_in = ST_LIFT_ANC;
         end
         // lift the deeper node to the depth of the other
         ST_LIFT_ANC: begin
            cmd.op   = tlca_pkg::OP_LIFT_ANC;
            state_in = ST_LIFT_DEP;
         end
         ST_LIFT_DEP: begin
            cmd.op   = tlca_pkg::OP_LIFT_DEP;
            state_in = ST_LIFT_CMP;
         end
         ST_LIFT_CMP: begin
            cmd.op  = tlca_pkg::OP_LIFT_CMP;
            cmd.lvl = lv_dec;
            if (lv_ff == '0) begin
               state_in = ST_Q_EQ;
            end else begin
               lv_in    = lv_dec;
               state_in = ST_LIFT_DEP;
            end
         end
         ST_Q_EQ: begin
            cmd.op  = tlca_pkg::OP_Q_EQ;
            cmd.lvl = tlca_pkg::LVL_LAST;
            lv_in   = tlca_pkg::LVL_LAST;
            if (status.nodes_equal) begin
               state_in = ST_Q_DIST;
            end else begin
               state_in = ST_CLIMB;
            end
         end
         // climb both nodes while their ancestors differ
         ST_CLIMB: begin
            cmd.op = tlca_pkg::OP_CLIMB;
            if (lv_ff == '0) begin
               cmd.lvl  = '0;
               state_in = ST_Q_PAR;
            end else begin
               cmd.lvl  = lv_dec;
               lv_in    = lv_dec;
            end
         end
         ST_Q_PAR: begin
            cmd.op   = tlca_pkg::OP_Q_PAR;
            state_in = ST_Q_DIST;
         end
         ST_Q_DIST: begin
            cmd.op   = tlca_pkg::OP_Q_DIST;
            state_in = ST_Q_OUT;
         end
         ST_Q_OUT: begin
            if (!status.rsp_busy) begin
               cmd.op   = tlca_pkg::OP_Q_OUT;
               state_in = ST_IDLE;
            end else begin
               // keep the lca distance read alive while the result port stalls
               cmd.op = tlca_pkg::OP_Q_DIST;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         lv_ff    <= '0;
      end else begin
         state_ff <= state_in;
         lv_ff    <= lv_in;
      end
   end

endmodule

@@ src/tlca_datapath.sv @@
// tlca_datapath: ancestor, depth and root distance memories, node registers,
// saturating adders and the result register; depends on tlca_pkg
`timescale 1ns / 1ps

module tlca_datapath (
   input  logic                     clock,
   input  logic                     reset,
   input  tlca_pkg::cmd_type        cmd,
   output tlca_pkg::status_type     status,
   input  logic                     req_command,
   input  tlca_pkg::node_type       req_node,
   input  tlca_pkg::node_type       req_other_node,
   input  tlca_pkg::weight_type     req_weight,
   input  logic                     rsp_ready,
   output logic                     rsp_valid,
   output tlca_pkg::node_type       rsp_common_ancestor,
   output tlca_pkg::path_type       rsp_path_length
);

   // working registers
   tlca_pkg::node_type   a_ff, a_in, b_ff, b_in;
   tlca_pkg::node_type   mid_ff, mid_in, up_ff, up_in, c_ff, c_in;
   tlca_pkg::weight_type w_ff, w_in;
   logic                 query_ff, query_in;
   tlca_pkg::depth_type  dep_lim_ff, dep_lim_in;
   tlca_pkg::path_type   sum_ff, sum_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   tlca_pkg::node_type   rsp_ca_ff, rsp_ca_in;
   tlca_pkg::path_type   rsp_pl_ff, rsp_pl_in;

   // memories and their ports
   tlca_pkg::node_type  anc_ram_ff [tlca_pkg::ANC_ENTRIES];
   tlca_pkg::depth_type dep_ram_ff [tlca_pkg::NODES];
   tlca_pkg::dist_type  dist_ram_ff [tlca_pkg::NODES];

   logic                                 anc_we, dep_we, dist_we;
   logic [tlca_pkg::ANC_ADDR_BITS-1:0]   anc_wa, anc_ra_a, anc_ra_b;
   tlca_pkg::node_type                   anc_wd;
   tlca_pkg::node_type                   dep_ra_a, dep_ra_b, dist_ra_a, dist_ra_b;
   tlca_pkg::depth_type                  dep_wd;
   tlca_pkg::dist_type                   dist_wd;

   tlca_pkg::node_type  anc_qa_ff, anc_qb_ff;
   tlca_pkg::depth_type dep_qa_ff, dep_qb_ff;
   tlca_pkg::dist_type  dist_qa_ff, dist_qb_ff;
   logic                anc_za_ff, anc_zb_ff, dep_za_ff, dep_zb_ff, dist_za_ff, dist_zb_ff;

   // read data, node 0 is the sentinel and reads as zero
   tlca_pkg::node_type  anc_a_rd, anc_b_rd;
   tlca_pkg::depth_type dep_a_rd, dep_b_rd;
   tlca_pkg::dist_type  dist_a_rd, dist_b_rd;

   logic [tlca_pkg::DEPTH_BITS:0] dep_inc;
   tlca_pkg::path_type            dist_add;
   tlca_pkg::path_type            twice_c;

   assign anc_a_rd  = anc_za_ff  ? '0 : anc_qa_ff;
   assign anc_b_rd  = anc_zb_ff  ? '0 : anc_qb_ff;
   assign dep_a_rd  = dep_za_ff  ? '0 : dep_qa_ff;
   assign dep_b_rd  = dep_zb_ff  ? '0 : dep_qb_ff;
   assign dist_a_rd = dist_za_ff ? '0 : dist_qa_ff;
   assign dist_b_rd = dist_zb_ff ? '0 : dist_qb_ff;

   // saturating depth and distance of a node being loaded
   assign dep_inc  = {1'b0, dep_a_rd} + (tlca_pkg::DEPTH_BITS + 1)'(1);
   assign dep_wd   = dep_inc[tlca_pkg::DEPTH_BITS] ? '1 : dep_inc[tlca_pkg::DEPTH_BITS-1:0];
   assign dist_add = tlca_pkg::PATH_BITS'(dist_a_rd) + tlca_pkg::PATH_BITS'(w_ff);
   assign dist_wd  = dist_add[tlca_pkg::DIST_BITS] ? '1 : dist_add[tlca_pkg::DIST_BITS-1:0];
   assign twice_c  = {dist_a_rd, 1'b0};

   // per-op register updates and memory addressing
   always_comb begin
      a_in         = a_ff;
      b_in         = b_ff;
      mid_in       = mid_ff;
      up_in        = up_ff;
      c_in         = c_ff;
      w_in         = w_ff;
      query_in     = query_ff;
      dep_lim_in   = dep_lim_ff;
      sum_in       = sum_ff;
      rsp_ca_in    = rsp_ca_ff;
      rsp_pl_in    = rsp_pl_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      anc_we       = 1'b0;
      anc_wa       = {a_ff, cmd.lvl};
      anc_wd       = anc_a_rd;
      anc_ra_a     = {a_ff, cmd.lvl};
      anc_ra_b     = {b_ff, cmd.lvl};
      dep_we       = 1'b0;
      dist_we      = 1'b0;
      dep_ra_a     = a_ff;
      dep_ra_b     = b_ff;
      dist_ra_a    = a_ff;
      dist_ra_b    = b_ff;
      case (cmd.op)
         tlca_pkg::OP_CAPTURE: begin
            a_in     = req_node;
            b_in     = req_other_node;
            w_in     = req_weight;
            query_in = (req_command == tlca_pkg::CMD_QUERY);
         end
         tlca_pkg::OP_LD_RD: begin
            dep_ra_a  = b_ff;
            dist_ra_a = b_ff;
            anc_we    = 1'b1;
            anc_wd    = b_ff;
            mid_in    = b_ff;
         end
         tlca_pkg::OP_LD_WR: begin
            dep_we  = 1'b1;
            dist_we = 1'b1;
         end
         tlca_pkg::OP_LD_ANC_RD: begin
            anc_ra_a = {mid_ff, cmd.lvl};
         end
         tlca_pkg::OP_LD_ANC_WR: begin
            anc_we = 1'b1;
            mid_in = anc_a_rd;
         end
         tlca_pkg::OP_Q_SWAP: begin
            sum_in = tlca_pkg::PATH_BITS'(dist_a_rd) + tlca_pkg::PATH_BITS'(dist_b_rd);
            if (dep_a_rd < dep_b_rd) begin
               a_in       = b_ff;
               b_in       = a_ff;
               dep_lim_in = dep_a_rd;
            end else begin
               dep_lim_in = dep_b_rd;
            end
         end
         tlca_pkg::OP_LIFT_DEP: begin
            up_in    = anc_a_rd;
            dep_ra_a = anc_a_rd;
         end
         tlca_pkg::OP_LIFT_CMP: begin
            if (dep_a_rd >= dep_lim_ff) begin
               a_in = up_ff;
            end
            anc_ra_a = {a_in, cmd.lvl};
         end
         tlca_pkg::OP_Q_EQ: begin
            c_in = a_ff;
         end
         tlca_pkg::OP_CLIMB: begin
            if (anc_a_rd != anc_b_rd) begin
               a_in = anc_a_rd;
               b_in = anc_b_rd;
            end
            anc_ra_a = {a_in, cmd.lvl};
            anc_ra_b = {b_in, cmd.lvl};
         end
         tlca_pkg::OP_Q_PAR: begin
            c_in = anc_a_rd;
         end
         tlca_pkg::OP_Q_DIST: begin
            dist_ra_a = c_ff;
         end
         tlca_pkg::OP_Q_OUT: begin
            rsp_valid_in = 1'b1;
            rsp_ca_in    = c_ff;
            rsp_pl_in    = (twice_c > sum_ff) ? '0 : sum_ff - twice_c;
         end
         default: begin
         end
      endcase
   end

   // ancestor memory: one write, two registered reads
   always_ff @(posedge clock) begin
      if (anc_we) begin
         anc_ram_ff[anc_wa] <= anc_wd;
      end
      anc_qa_ff <= anc_ram_ff[anc_ra_a];
      anc_qb_ff <= anc_ram_ff[anc_ra_b];
      anc_za_ff <= (anc_ra_a[tlca_pkg::ANC_ADDR_BITS-1:tlca_pkg::LVL_BITS] == '0);
      anc_zb_ff <= (anc_ra_b[tlca_pkg::ANC_ADDR_BITS-1:tlca_pkg::LVL_BITS] == '0);
   end

   // depth memory
   always_ff @(posedge clock) begin
      if (dep_we) begin
         dep_ram_ff[a_ff] <= dep_wd;
      end
      dep_qa_ff <= dep_ram_ff[dep_ra_a];
      dep_qb_ff <= dep_ram_ff[dep_ra_b];
      dep_za_ff <= (dep_ra_a == '0);
      dep_zb_ff <= (dep_ra_b == '0);
   end

   // root distance memory
   always_ff @(posedge clock) begin
      if (dist_we) begin
         dist_ram_ff[a_ff] <= dist_wd;
      end
      dist_qa_ff <= dist_ram_ff[dist_ra_a];
      dist_qb_ff <= dist_ram_ff[dist_ra_b];
      dist_za_ff <= (dist_ra_a == '0);
      dist_zb_ff <= (dist_ra_b == '0);
   end

   // payload registers
   always_ff @(posedge clock) begin
      a_ff       <= a_in;
      b_ff       <= b_in;
      mid_ff     <= mid_in;
      up_ff      <= up_in;
      c_ff       <= c_in;
      w_ff       <= w_in;
      query_ff   <= query_in;
      dep_lim_ff <= dep_lim_in;
      sum_ff     <= sum_in;
      rsp_ca_ff  <= rsp_ca_in;
      rsp_pl_ff  <= rsp_pl_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign status.is_query    = query_ff;
   assign status.node_zero   = (a_ff == '0);
   assign status.nodes_equal = (a_ff == b_ff);
   assign status.rsp_busy    = rsp_valid_ff && !rsp_ready;

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_common_ancestor = rsp_ca_ff;
   assign rsp_path_length     = rsp_pl_ff;

endmodule

@@ src/tlca_checker.sv @@
// tlca_checker: port level checks of the lca unit over time, bound to the
// top level; depends on tlca_pkg and tree_lca_distance_query_unit
`timescale 1ns / 1ps

module tlca_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input logic                 req_command,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input tlca_pkg::node_type   rsp_common_ancestor,
   input tlca_pkg::path_type   rsp_path_length
);

   // a stalled result item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_common_ancestor)
                                  && $stable(rsp_path_length))
      else $error("result item changed while stalled");

   // one item in work at a time
   a_single_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second item accepted while busy");

   // a load raises no result item right after it is accepted
   a_load_silent: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_command == tlca_pkg::CMD_LOAD) |=> !$rose(rsp_valid))
      else $error("result item right after a load");

   // a new result only comes out of the busy sequencer
   a_rsp_from_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("result item raised while idle");

endmodule

bind tree_lca_distance_query_unit tlca_checker u_checker (.*);

@@ dv/tree_lca_distance_query_unit_tb.sv @@
// testbench for tree_lca_distance_query_unit: a stimulus table, random forests and a
// self-parent run, each result checked against an in-bench binary lifting predictor
// or a hand-typed value; depends on tlca_pkg and tree_lca_distance_query_unit
`timescale 1ns / 1ps

module tree_lca_distance_query_unit_tb;

   localparam tlca_pkg::weight_type WEIGHT_TOP   = '1;
   localparam int                   IDLE_LIMIT   = 2000;
   localparam int                   DRAIN_CYCLES = 60;
   localparam int                   RANDOM_ITEMS = 760;
   localparam int                   SELF_LOADS   = 56;
   localparam int                   REPORT_MAX   = 10;

   // one row of the directed part; fixed marks a hand-typed expected result
   typedef struct packed {
      logic                 command;
      tlca_pkg::node_type   node;
      tlca_pkg::node_type   other;
      tlca_pkg::weight_type weight;
      logic                 fixed;
      tlca_pkg::node_type   anc;
      tlca_pkg::path_type   path;
   } script_row_type;

   typedef struct packed {
      tlca_pkg::node_type anc;
      tlca_pkg::path_type path;
   } lca_result_type;

   typedef enum logic [1:0] {SINK_FREE, SINK_COIN, SINK_HOLD} sink_mode_type;

   localparam script_row_type SCRIPT [23] = '{
      '{tlca_pkg::CMD_LOAD,  10'd1,    10'd0,    WEIGHT_TOP, 1'b0, 10'd0,    41'd0},
      '{tlca_pkg::CMD_QUERY, 10'd1,    10'd0,    30'd0,      1'b1, 10'd0,    41'h3FFF_FFFF},
      '{tlca_pkg::CMD_QUERY, 10'd1,    10'd1,    30'd0,      1'b1, 10'd1,    41'd0},
      '{tlca_pkg::CMD_LOAD,  10'd1023, 10'd1,    30'd0,      1'b0, 10'd0,    41'd0},
      '{tlca_pkg::CMD_QUERY, 10'd1023, 10'd1,    30'd0,      1'b1, 10'd1,    41'd0},
      '{tlca_pkg::CMD_LOAD,  10'd512,  10'd1023, WEIGHT_TOP, 1'b0, 10'd0,    41'd0},
      '{tlca_pkg::CMD_LOAD,  10'd2,    10'd0,    30'd5,      1'b0, 10'd0,    41'd0},
      '{tlca_pkg::CMD_QUERY, 10'd512,  10'd2,    30'd0,      1'b1, 10'd0,    41'h8000_0003},
      '{tlca_pkg::CMD_LOAD,  10'd3,    10'd1,    30'd7,      1'b0, 10'd0,    41'd0},
      '{tlca_pkg::CMD_QUERY, 10'd512,  10'd3,    30'd0,      1'b0, 10'd0,    41'd0},
      '{tlca_pkg::CMD_QUERY, 10'd3,    10'd512,  WEIGHT_TOP, 1'b0, 10'd0,    41'd0},
      '{tlca_pkg::CMD_LOAD,  10'd0,    10'd1,    30'd9,      1'b0, 10'd0,    41'd0},
      '{tlca_pkg::CMD_QUERY, 10'd1,    10'd0,    30'd0,      1'b1, 10'd0,    41'h3FFF_FFFF},
      '{tlca_pkg::CMD_LOAD,  10'd4,    10'd3,    30'd2,      1'b0, 10'd0,    41'd0},
      '{tlca_pkg::CMD_QUERY, 10'd4,    10'd1023, 30'd0,      1'b0, 10'd0,    41'd0},
      '{tlca_pkg::CMD_LOAD,  10'd4,    10'd4,    30'd3,      1'b0, 10'd0,    41'd0},
      '{tlca_pkg::CMD_QUERY, 10'd4,    10'd4,    30'd0,      1'b1, 10'd4,    41'd0},
      '{tlca_pkg::CMD_QUERY, 10'd4,    10'd3,    30'd0,      1'b0, 10'd0,    41'd0},
      '{tlca_pkg::CMD_LOAD,  10'd3,    10'd2,    30'd100,    1'b0, 10'd0,    41'd0},
      '{tlca_pkg::CMD_QUERY, 10'd4,    10'd2,    30'd0,      1'b0, 10'd0,    41'd0},
      '{tlca_pkg::CMD_QUERY, 10'd1023, 10'd1023, 30'd0,      1'b1, 10'd1023, 41'd0},
      '{tlca_pkg::CMD_QUERY, 10'd512,  10'd1023, 30'd0,      1'b0, 10'd0,    41'd0},
      '{tlca_pkg::CMD_QUERY, 10'd2,    10'd0,    30'd0,      1'b1, 10'd0,    41'd5}
   };

   logic                 clock;
   logic                 reset          = 1'b1;
   logic                 req_valid      = 1'b0;
   logic                 req_ready;
   logic                 req_command    = tlca_pkg::CMD_LOAD;
   tlca_pkg::node_type   req_node       = '0;
   tlca_pkg::node_type   req_other_node = '0;
   tlca_pkg::weight_type req_weight     = '0;
   logic                 rsp_valid;
   logic                 rsp_ready      = 1'b0;
   tlca_pkg::node_type   rsp_common_ancestor;
   tlca_pkg::path_type   rsp_path_length;

   // predictor copy of the tables
   tlca_pkg::node_type  hop_mem   [tlca_pkg::NODES][tlca_pkg::LEVELS];
   tlca_pkg::depth_type depth_mem [tlca_pkg::NODES];
   tlca_pkg::dist_type  dist_mem  [tlca_pkg::NODES];
   bit                  is_loaded [tlca_pkg::NODES];
   tlca_pkg::node_type  loaded_ids [$];
   tlca_pkg::node_type  deepest_id = '0;

   lca_result_type pending_results [$];
   lca_result_type head_result;
   int             fault_count = 0;
   int             idle_cycles = 0;
   int             burst_left  = 0;
   sink_mode_type  sink_mode   = SINK_FREE;
   int             sink_left   = 0;

   tree_lca_distance_query_unit DUT (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_command         (req_command),
      .req_node            (req_node),
      .req_other_node      (req_other_node),
      .req_weight          (req_weight),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_common_ancestor (rsp_common_ancestor),
      .rsp_path_length     (rsp_path_length)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // load: depth and distance from the parent, then the ancestor ladder
   function automatic void record_node_load(tlca_pkg::node_type n, tlca_pkg::node_type p,
                                            tlca_pkg::weight_type w);
      logic [tlca_pkg::DIST_BITS:0]  dist_sum;
      logic [tlca_pkg::DEPTH_BITS:0] depth_sum;
      if (n == '0) return;
      dist_sum  = dist_mem[p] + w;
      depth_sum = depth_mem[p] + 1'b1;
      dist_mem[n]   = dist_sum[tlca_pkg::DIST_BITS] ? '1 : dist_sum[tlca_pkg::DIST_BITS-1:0];
      depth_mem[n]  = depth_sum[tlca_pkg::DEPTH_BITS] ? '1
                                                      : depth_sum[tlca_pkg::DEPTH_BITS-1:0];
      hop_mem[n][0] = p;
      for (int lv = 1; lv < tlca_pkg::LEVELS; lv++)
         hop_mem[n][lv] = hop_mem[hop_mem[n][lv-1]][lv-1];
      if (!is_loaded[n]) begin
         is_loaded[n] = 1'b1;
         loaded_ids.insert(loaded_ids.size(), n);
      end
      if (depth_mem[n] >= depth_mem[deepest_id])
         deepest_id = n;
   endfunction

   // lift the deeper node, then climb both while their ancestors differ
   function automatic tlca_pkg::node_type lowest_common_of(tlca_pkg::node_type a,
                                                           tlca_pkg::node_type b);
      tlca_pkg::node_type t;
      if (depth_mem[a] < depth_mem[b]) begin
         t = a;
         a = b;
         b = t;
      end
      for (int lv = tlca_pkg::LEVELS - 1; lv >= 0; lv--)
         if (depth_mem[hop_mem[a][lv]] >= depth_mem[b])
            a = hop_mem[a][lv];
      if (a == b) return a;
      for (int lv = tlca_pkg::LEVELS - 1; lv >= 0; lv--)
         if (hop_mem[a][lv] != hop_mem[b][lv]) begin
            a = hop_mem[a][lv];
            b = hop_mem[b][lv];
         end
      return hop_mem[a][0];
   endfunction

   // once over 16 nodes are loaded, half the picks come from the 16 most recent loads, where the trees are deep
   function automatic tlca_pkg::node_type pick_loaded();
      int cnt = loaded_ids.size();
      if (cnt > 16 && $urandom_range(0, 1) == 1)
         return loaded_ids[$urandom_range(cnt - 16, cnt - 1)];
      return loaded_ids[$urandom_range(0, cnt - 1)];
   endfunction

   function automatic tlca_pkg::node_type fresh_node();
      tlca_pkg::node_type n;
      if (loaded_ids.size() >= tlca_pkg::NODES - 1)
         return tlca_pkg::node_type'($urandom_range(1, tlca_pkg::NODES - 1));
      do n = tlca_pkg::node_type'($urandom_range(1, tlca_pkg::NODES - 1));
      while (is_loaded[n]);
      return n;
   endfunction

   // present one item, wait for the handshake, predict, then pace the next burst
   task automatic send_item(input logic cmd, input tlca_pkg::node_type n,
                            input tlca_pkg::node_type o, input tlca_pkg::weight_type w,
                            input logic fixed, input tlca_pkg::node_type fixed_anc,
                            input tlca_pkg::path_type fixed_path);
      lca_result_type     want;
      tlca_pkg::node_type meet;
      tlca_pkg::path_type both;
      tlca_pkg::path_type twice;
      req_valid      <= 1'b1;
      req_command    <= cmd;
      req_node       <= n;
      req_other_node <= o;
      req_weight     <= w;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (cmd == tlca_pkg::CMD_LOAD) begin
         record_node_load(n, o, w);
      end else begin
         meet  = lowest_common_of(n, o);
         both  = dist_mem[n] + dist_mem[o];
         twice = {dist_mem[meet], 1'b0};
         want.anc  = fixed ? fixed_anc : meet;
         want.path = fixed ? fixed_path : ((twice > both) ? '0 : both - twice);
         pending_results.insert(pending_results.size(), want);
      end
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 20);
         if ($urandom_range(0, 3) != 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
      end
   endtask

   // stimulus
   initial begin
      tlca_pkg::node_type   n;
      tlca_pkg::node_type   o;
      tlca_pkg::weight_type w;
      tlca_pkg::node_type   sat_id;
      tlca_pkg::node_type   sat_child;
      int                   roll;
      for (int i = 0; i < tlca_pkg::NODES; i++) begin
         depth_mem[i] = '0;
         dist_mem[i]  = '0;
         is_loaded[i] = 1'b0;
         for (int j = 0; j < tlca_pkg::LEVELS; j++) hop_mem[i][j] = '0;
      end
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table
      foreach (SCRIPT[i])
         send_item(SCRIPT[i].command, SCRIPT[i].node, SCRIPT[i].other, SCRIPT[i].weight,
                   SCRIPT[i].fixed, SCRIPT[i].anc, SCRIPT[i].path);

      // random forests, mostly grown along the deepest chain
      repeat (RANDOM_ITEMS) begin
         if ($urandom_range(0, 99) < 72) begin
            n = ($urandom_range(0, 9) != 0)
                   ? fresh_node()
                   : tlca_pkg::node_type'($urandom_range(1, tlca_pkg::NODES - 1));
            roll = $urandom_range(0, 99);
            if (roll < 87) o = deepest_id;
            else if (roll < 93) o = '0;
            else if (roll < 98 || !is_loaded[n]) o = pick_loaded();
            else o = n;
            roll = $urandom_range(0, 99);
            if (roll < 15) w = WEIGHT_TOP;
            else if (roll < 30) w = tlca_pkg::weight_type'($urandom_range(0, 15));
            else w = tlca_pkg::weight_type'($urandom);
            send_item(tlca_pkg::CMD_LOAD, n, o, w, 1'b0, '0, '0);
         end else begin
            n    = pick_loaded();
            roll = $urandom_range(0, 99);
            o    = (roll < 10) ? tlca_pkg::node_type'(0) : (roll < 20) ? n : pick_loaded();
            send_item(tlca_pkg::CMD_QUERY, n, o, tlca_pkg::weight_type'($urandom),
                      1'b0, '0, '0);
         end
      end

      // repeated self-parent loads stack depth and distance on one node
      sat_id = fresh_node();
      send_item(tlca_pkg::CMD_LOAD, sat_id, '0, WEIGHT_TOP, 1'b0, '0, '0);
      repeat (SELF_LOADS)
         send_item(tlca_pkg::CMD_LOAD, sat_id, sat_id, WEIGHT_TOP, 1'b0, '0, '0);
      sat_child = fresh_node();
      send_item(tlca_pkg::CMD_LOAD, sat_child, sat_id, WEIGHT_TOP, 1'b0, '0, '0);
      send_item(tlca_pkg::CMD_QUERY, sat_id, sat_id, '0, 1'b0, '0, '0);
      send_item(tlca_pkg::CMD_QUERY, sat_id, '0, '0, 1'b0, '0, '0);
      send_item(tlca_pkg::CMD_QUERY, sat_child, sat_id, '0, 1'b0, '0, '0);
      send_item(tlca_pkg::CMD_QUERY, sat_child, '0, '0, 1'b0, '0, '0);
      repeat (6)
         send_item(tlca_pkg::CMD_QUERY, pick_loaded(), sat_child, '0, 1'b0, '0, '0);
      req_valid <= 1'b0;

      // drain and settle
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fault_count == 0)
         $display("tree_lca_distance_query_unit_tb: clean");
      else
         $display("tree_lca_distance_query_unit_tb: errors");
      $finish;
   end

   // receiver: free-running, coin-toss and hold stretches
   always @(posedge clock) begin
      if (sink_left == 0) begin
         sink_mode <= sink_mode_type'($urandom_range(0, 2));
         sink_left <= $urandom_range(1, 40);
      end else begin
         sink_left <= sink_left - 1;
      end
      case (sink_mode)
         SINK_FREE: rsp_ready <= 1'b1;
         SINK_COIN: rsp_ready <= ($urandom_range(0, 1) == 1);
         default:   rsp_ready <= 1'b0;
      endcase
   end

   // result check against the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            fault_count++;
            if (fault_count <= REPORT_MAX)
               $display("unexpected result item: ancestor %0d path %0d",
                        rsp_common_ancestor, rsp_path_length);
         end else begin
            head_result = pending_results.pop_front();
            if (rsp_common_ancestor !== head_result.anc ||
                rsp_path_length !== head_result.path) begin
               fault_count++;
               if (fault_count <= REPORT_MAX)
                  $display("result mismatch: ancestor exp %0d got %0d, path exp %0d got %0d",
                           head_result.anc, rsp_common_ancestor,
                           head_result.path, rsp_path_length);
            end
         end
      end
   end

   // watchdog on cycles with no item moving on either side
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == IDLE_LIMIT) begin
         $display("tree_lca_distance_query_unit_tb: errors");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule
